@@ src/mbrs_pkg.sv @@
// Shared types, codes and CRC helper for the Modbus RTU register server.
`timescale 1ns / 1ps
`default_nettype none
package mbrs_pkg;

  localparam int RX_BUF_BYTES_DEF  = 256;
  localparam int HOLDING_DEPTH_DEF = 256;
  localparam int INPUT_DEPTH_DEF   = 256;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 56;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // input item kinds
  localparam logic [1:0] KIND_RX_BYTE = 2'd0;
  localparam logic [1:0] KIND_SILENCE = 2'd1;
  localparam logic [1:0] KIND_LWRITE  = 2'd2;
  localparam logic [1:0] KIND_LREAD   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDING_BASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDING_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_BASE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SIZE    = 3'd4;

  // function codes and exception codes
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_READ_INPUT   = 8'h04;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;
  localparam logic [7:0] FC_EXC_FLAG     = 8'h80;
  localparam logic [7:0] EXC_NONE         = 8'h00;
  localparam logic [7:0] EXC_ILLEGAL_FC   = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'h02;
  localparam logic [7:0] EXC_ILLEGAL_VAL  = 8'h03;
  localparam logic [15:0] READ_MAX  = 16'd125;
  localparam logic [15:0] WRITE_MAX = 16'd123;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // one byte (or one local read result) handed to the reply packer
  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
    logic        last;
    logic        local_rd;
    logic [15:0] read_data;
  } tx_push_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    begin
      c = crc ^ {8'h00, d};
      for (int b = 0; b < 8; b++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    end
  endfunction

endpackage
`default_nettype wire

@@ src/modbus_rtu_register_server.sv @@
// Top level of the Modbus RTU register server: frame buffer, register stores, sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Modbus RTU slave. Line bytes (tuser kind 0) are stored in a frame buffer
// memory; a silence item (kind 1) ends the frame. The sequencer then walks the
// buffer byte by byte to check length, address and CRC-16, decodes
// FC03/FC04/FC06/FC16, reads the holding or input register memory or writes
// the holding one register at a time, and streams the reply with its CRC out
// up to four bytes per transfer; tlast marks the item with the final byte.
// Bad, short or foreign frames are dropped without output. Local writes
// (kind 2) are done when accepted; local reads (kind 3) give one transfer
// with tx_count 0. Each memory has a single read port. One item is handled
// at a time. After reset a clearing pass zeroes both register memories,
// during which no item is accepted; configuration writes are taken at any
// time.
module modbus_rtu_register_server
  import mbrs_pkg::*;
#(
  parameter int RX_BUF_BYTES  = RX_BUF_BYTES_DEF,
  parameter int HOLDING_DEPTH = HOLDING_DEPTH_DEF,
  parameter int INPUT_DEPTH   = INPUT_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [S_TDATA_W-1:0]  s_tdata,  // rx_byte[7:0], local_bank[8], local_addr[24:9], local_value[40:25]
  input  wire logic [1:0]            s_tuser,  // kind[1:0]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [M_TDATA_W-1:0]       m_tdata,  // tx_bytes[31:0], tx_count[34:32], local_read_data[50:35]
  output logic                       m_tlast
);

  localparam int LW  = $clog2(RX_BUF_BYTES + 1);
  localparam int BAW = $clog2(RX_BUF_BYTES);
  localparam int HAW = (HOLDING_DEPTH > 1) ? $clog2(HOLDING_DEPTH) : 1;
  localparam int IAW = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
  localparam int CLR_N = (HOLDING_DEPTH > INPUT_DEPTH) ? HOLDING_DEPTH : INPUT_DEPTH;
  localparam int CW  = $clog2(CLR_N + 1);
  localparam logic [16:0] HOLD_DEPTH_W = 17'(HOLDING_DEPTH);
  localparam logic [16:0] INP_DEPTH_W  = 17'(INPUT_DEPTH);

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_LRD    = 14'b00000000000100,
    S_RX_RD  = 14'b00000000001000,
    S_RX_DAT = 14'b00000000010000,
    S_DECIDE = 14'b00000000100000,
    S_W_RD   = 14'b00000001000000,
    S_W_DAT  = 14'b00000010000000,
    S_FIX    = 14'b00000100000000,
    S_REG_RD = 14'b00001000000000,
    S_REG_HI = 14'b00010000000000,
    S_REG_LO = 14'b00100000000000,
    S_CRC_LO = 14'b01000000000000,
    S_CRC_HI = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [7:0]  slave_address;
  logic [15:0] holding_base, input_base;
  logic [8:0]  holding_size, input_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
      holding_base  <= 16'd0;
      holding_size  <= 9'd0;
      input_base    <= 16'd0;
      input_size    <= 9'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDRESS: slave_address <= cfg_data[7:0];
        CFG_HOLDING_BASE:  holding_base  <= cfg_data;
        CFG_HOLDING_SIZE:  holding_size  <= cfg_data[8:0];
        CFG_INPUT_BASE:    input_base    <= cfg_data;
        CFG_INPUT_SIZE:    input_size    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // window sizes clamped to the memory depth
  logic [16:0] hold_eff, inp_eff;
  assign hold_eff = ({8'd0, holding_size} < HOLD_DEPTH_W) ? {8'd0, holding_size} : HOLD_DEPTH_W;
  assign inp_eff  = ({8'd0, input_size} < INP_DEPTH_W) ? {8'd0, input_size} : INP_DEPTH_W;

  function automatic logic win_ok(input logic [15:0] base, input logic [16:0] eff,
                                  input logic [15:0] start, input logic [15:0] cnt);
    logic [17:0] e;
    begin
      e = {2'b00, start} + {2'b00, cnt};
      return (start >= base) && (e <= 18'h10000) && ((e - {2'b00, base}) <= {1'b0, eff});
    end
  endfunction

  // input fields
  logic [1:0]  kind;
  logic [7:0]  rx_byte;
  logic        local_bank;
  logic [15:0] local_addr, local_value;
  assign kind        = s_tuser;
  assign rx_byte     = s_tdata[7:0];
  assign local_bank  = s_tdata[8];
  assign local_addr  = s_tdata[24:9];
  assign local_value = s_tdata[40:25];

  logic accept;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  logic        lh_ok, li_ok;
  logic [15:0] lh_off, li_off;
  assign lh_ok  = win_ok(holding_base, hold_eff, local_addr, 16'd1);
  assign li_ok  = win_ok(input_base, inp_eff, local_addr, 16'd1);
  assign lh_off = local_addr - holding_base;
  assign li_off = local_addr - input_base;

  // frame buffer memory
  logic [7:0]     frame_mem [RX_BUF_BYTES];
  logic           buf_we, buf_re;
  logic [BAW-1:0] buf_waddr, buf_raddr;
  logic [7:0]     buf_q;

  always_ff @(posedge clk) begin
    if (buf_we) frame_mem[buf_waddr] <= rx_byte;
    if (buf_re) buf_q <= frame_mem[buf_raddr];
  end

  // register memories
  logic [15:0]    hold_mem [HOLDING_DEPTH];
  logic [15:0]    inp_mem  [INPUT_DEPTH];
  logic           hold_we, hold_re, inp_we, inp_re;
  logic [HAW-1:0] hold_waddr, hold_raddr;
  logic [IAW-1:0] inp_waddr, inp_raddr;
  logic [15:0]    hold_wdata, inp_wdata, hold_q, inp_q;

  always_ff @(posedge clk) begin
    if (hold_we) hold_mem[hold_waddr] <= hold_wdata;
    if (hold_re) hold_q <= hold_mem[hold_raddr];
  end

  always_ff @(posedge clk) begin
    if (inp_we) inp_mem[inp_waddr] <= inp_wdata;
    if (inp_re) inp_q <= inp_mem[inp_raddr];
  end

  // sequencer registers
  logic [CW-1:0] clr;
  logic [LW-1:0] frame_length, idx, wptr;
  logic [15:0]   rcrc;
  logic [7:0]    hdr [7];
  logic [15:0]   tail;
  logic [7:0]    fix [6];
  logic [2:0]    fix_n, fix_i;
  logic          is_read, is_input, wphase, lr_ok, lr_bank;
  logic [15:0]   off;
  logic [6:0]    rcnt;
  logic [7:0]    whi, crc_hi;

  // decoded frame
  logic [7:0]  fc;
  logic [15:0] f_start, f_count;
  logic [7:0]  f_bc;
  logic        f_win;
  logic [15:0] f_base;
  logic [16:0] f_eff;
  logic        f_rd;
  logic [7:0]  d_exc;
  assign fc      = hdr[1];
  assign f_start = {hdr[2], hdr[3]};
  assign f_count = {hdr[4], hdr[5]};
  assign f_bc    = hdr[6];
  assign f_base  = (fc == FC_READ_INPUT) ? input_base : holding_base;
  assign f_eff   = (fc == FC_READ_INPUT) ? inp_eff : hold_eff;
  assign f_win   = win_ok(f_base, f_eff, f_start,
                          (fc == FC_WRITE_SINGLE) ? 16'd1 : f_count);
  assign f_rd    = (fc == FC_READ_HOLDING) || (fc == FC_READ_INPUT);

  // exception code of the decoded request, EXC_NONE when it is served
  always_comb begin
    d_exc = EXC_NONE;
    if (f_rd) begin
      if (frame_length != LW'(8) || f_count == 16'd0 || f_count > READ_MAX)
        d_exc = EXC_ILLEGAL_VAL;
      else if (!f_win)
        d_exc = EXC_ILLEGAL_ADDR;
    end else if (fc == FC_WRITE_SINGLE) begin
      if (frame_length != LW'(8))
        d_exc = EXC_ILLEGAL_VAL;
      else if (!f_win)
        d_exc = EXC_ILLEGAL_ADDR;
    end else if (fc == FC_WRITE_MULTI) begin
      if (frame_length < LW'(9) || f_count == 16'd0 || f_count > WRITE_MAX ||
          {9'd0, f_bc} != {f_count, 1'b0} ||
          11'(frame_length) != 11'(LW'(9) + f_bc))
        d_exc = EXC_ILLEGAL_VAL;
      else if (!f_win)
        d_exc = EXC_ILLEGAL_ADDR;
    end else begin
      d_exc = EXC_ILLEGAL_FC;
    end
  end

  logic frame_ok;
  assign frame_ok = (hdr[0] == slave_address) && (tail == {rcrc[7:0], rcrc[15:8]});

  logic       tx_ready;
  logic [15:0] tx_crc;
  tx_push_t   push;

  mbrs_tx_packer u_packer (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .ready    (tx_ready),
    .crc      (tx_crc),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // memory port steering and reply bytes
  always_comb begin
    state_next = state;
    buf_we     = 1'b0;
    buf_waddr  = (frame_length >= LW'(RX_BUF_BYTES)) ? '0 : frame_length[BAW-1:0];
    buf_re     = 1'b0;
    buf_raddr  = idx[BAW-1:0];
    hold_we    = 1'b0;
    hold_waddr = off[HAW-1:0];
    hold_wdata = {whi, buf_q};
    hold_re    = 1'b0;
    hold_raddr = off[HAW-1:0];
    inp_we     = 1'b0;
    inp_waddr  = li_off[IAW-1:0];
    inp_wdata  = local_value;
    inp_re     = 1'b0;
    inp_raddr  = off[IAW-1:0];
    push       = '0;
    unique case (state)
      S_CLEAR: begin
        hold_we    = (clr < CW'(HOLDING_DEPTH));
        hold_waddr = clr[HAW-1:0];
        hold_wdata = 16'd0;
        inp_we     = (clr < CW'(INPUT_DEPTH));
        inp_waddr  = clr[IAW-1:0];
        inp_wdata  = 16'd0;
        if (clr == CW'(CLR_N - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_RX_BYTE: buf_we = 1'b1;
            KIND_SILENCE: begin
              if (frame_length >= LW'(4)) state_next = S_RX_RD;
            end
            KIND_LWRITE: begin
              hold_we    = !local_bank && lh_ok;
              hold_waddr = lh_off[HAW-1:0];
              hold_wdata = local_value;
              inp_we     = local_bank && li_ok;
            end
            KIND_LREAD: begin
              hold_re    = !local_bank;
              hold_raddr = lh_off[HAW-1:0];
              inp_re     = local_bank;
              inp_raddr  = li_off[IAW-1:0];
              state_next = S_LRD;
            end
            default: ;
          endcase
        end
      end
      S_LRD: begin
        if (tx_ready) begin
          push.valid     = 1'b1;
          push.local_rd  = 1'b1;
          push.read_data = !lr_ok ? 16'd0 : (lr_bank ? inp_q : hold_q);
          state_next     = S_IDLE;
        end
      end
      S_RX_RD: begin
        buf_re     = 1'b1;
        state_next = S_RX_DAT;
      end
      S_RX_DAT: begin
        state_next = (idx + LW'(1) == frame_length) ? S_DECIDE : S_RX_RD;
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        if (frame_ok) begin
          state_next = S_FIX;
          if (fc == FC_WRITE_SINGLE && d_exc == EXC_NONE) begin
            hold_we    = 1'b1;
            hold_waddr = HAW'(f_start - holding_base);
            hold_wdata = f_count;
          end
          if (fc == FC_WRITE_MULTI && d_exc == EXC_NONE) state_next = S_W_RD;
        end
      end
      S_W_RD: begin
        buf_re     = 1'b1;
        buf_raddr  = wptr[BAW-1:0];
        state_next = S_W_DAT;
      end
      S_W_DAT: begin
        if (wphase) begin
          hold_we = 1'b1;
          state_next = (rcnt == 7'd1) ? S_FIX : S_W_RD;
        end else begin
          state_next = S_W_RD;
        end
      end
      S_FIX: begin
        if (tx_ready) begin
          push.valid = 1'b1;
          push.data  = fix[fix_i];
          if (fix_i + 3'd1 == fix_n) state_next = is_read ? S_REG_RD : S_CRC_LO;
        end
      end
      S_REG_RD: begin
        hold_re    = !is_input;
        inp_re     = is_input;
        state_next = S_REG_HI;
      end
      S_REG_HI: begin
        if (tx_ready) begin
          push.valid = 1'b1;
          push.data  = is_input ? inp_q[15:8] : hold_q[15:8];
          state_next = S_REG_LO;
        end
      end
      S_REG_LO: begin
        if (tx_ready) begin
          push.valid = 1'b1;
          push.data  = is_input ? inp_q[7:0] : hold_q[7:0];
          state_next = (rcnt == 7'd1) ? S_CRC_LO : S_REG_RD;
        end
      end
      S_CRC_LO: begin
        if (tx_ready) begin
          push.valid = 1'b1;
          push.data  = tx_crc[7:0];
          state_next = S_CRC_HI;
        end
      end
      S_CRC_HI: begin
        if (tx_ready) begin
          push.valid = 1'b1;
          push.data  = crc_hi;
          push.last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      frame_length <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: clr <= clr + CW'(1);
        S_IDLE: begin
          if (accept) begin
            unique case (kind)
              KIND_RX_BYTE: frame_length <= {1'b0, buf_waddr} + LW'(1);
              KIND_SILENCE: begin
                if (frame_length < LW'(4)) frame_length <= '0;
                idx  <= '0;
                rcrc <= CRC_INIT;
              end
              KIND_LREAD: begin
                lr_bank <= local_bank;
                lr_ok   <= local_bank ? li_ok : lh_ok;
              end
              default: ;
            endcase
          end
        end
        S_RX_DAT: begin
          if (idx + LW'(2) < frame_length) rcrc <= crc16_byte(rcrc, buf_q);
          if (idx < LW'(7)) hdr[idx[2:0]] <= buf_q;
          tail <= {tail[7:0], buf_q};
          idx  <= idx + LW'(1);
        end
        S_DECIDE: begin
          // build the fixed reply head: echo, read header or exception
          frame_length <= '0;
          is_read  <= f_rd && (d_exc == EXC_NONE);
          is_input <= (fc == FC_READ_INPUT);
          fix[0]   <= slave_address;
          fix[1]   <= (d_exc == EXC_NONE) ? fc : (fc | FC_EXC_FLAG);
          fix[2]   <= (d_exc != EXC_NONE) ? d_exc :
                      (f_rd ? {f_count[6:0], 1'b0} : hdr[2]);
          fix[3]   <= hdr[3];
          fix[4]   <= hdr[4];
          fix[5]   <= hdr[5];
          fix_n    <= (d_exc == EXC_NONE && !f_rd) ? 3'd6 : 3'd3;
          fix_i    <= 3'd0;
          off      <= f_start - f_base;
          rcnt     <= f_count[6:0];
          wptr     <= LW'(7);
          wphase   <= 1'b0;
        end
        S_W_DAT: begin
          wptr   <= wptr + LW'(1);
          wphase <= !wphase;
          if (!wphase) whi <= buf_q;
          else begin
            off  <= off + 16'd1;
            rcnt <= rcnt - 7'd1;
          end
        end
        S_FIX: if (tx_ready) fix_i <= fix_i + 3'd1;
        S_REG_LO: begin
          if (tx_ready) begin
            off  <= off + 16'd1;
            rcnt <= rcnt - 7'd1;
          end
        end
        S_CRC_LO: if (tx_ready) crc_hi <= tx_crc[15:8];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/mbrs_tx_packer.sv @@
// Reply packer: folds reply bytes into items of up to four bytes, keeps the running CRC.
`timescale 1ns / 1ps
`default_nettype none
module mbrs_tx_packer
  import mbrs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tx_push_t             push,
  output logic                      ready,
  output logic [15:0]               crc,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,  // tx_bytes[31:0], tx_count[34:32], local_read_data[50:35]
  output logic                      m_tlast
);

  logic [23:0] acc;
  logic [1:0]  acc_cnt;
  logic [31:0] word;

  assign ready = !m_tvalid || m_tready;

  always_comb begin
    word = {8'h00, acc};
    unique case (acc_cnt)
      2'd0: word[7:0]   = push.data;
      2'd1: word[15:8]  = push.data;
      2'd2: word[23:16] = push.data;
      2'd3: word[31:24] = push.data;
      default: word = {8'h00, acc};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      acc      <= 24'd0;
      acc_cnt  <= 2'd0;
      crc      <= CRC_INIT;
    end else begin
      if (push.valid && (push.local_rd || acc_cnt == 2'd3 || push.last)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (push.valid) begin
        if (push.local_rd) begin
          m_tlast  <= 1'b0;
          m_tdata  <= {5'd0, push.read_data, 3'd0, 32'd0};
        end else if (acc_cnt == 2'd3 || push.last) begin
          m_tlast  <= push.last;
          m_tdata  <= {5'd0, 16'd0, {1'b0, acc_cnt} + 3'd1, word};
          acc      <= 24'd0;
          acc_cnt  <= 2'd0;
          crc      <= push.last ? CRC_INIT : crc16_byte(crc, push.data);
        end else begin
          acc      <= word[23:0];
          acc_cnt  <= acc_cnt + 2'd1;
          crc      <= crc16_byte(crc, push.data);
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_modbus_rtu_register_server.sv @@
// Self-checking testbench for the Modbus RTU register server.
`timescale 1ns / 1ps
`default_nettype none
module tb_modbus_rtu_register_server;
  import mbrs_pkg::*;

  // Reply word as it comes out of the block: packed bytes, byte count,
  // end-of-reply flag and the value of a local read.
  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  count;
    logic        last;
    logic [15:0] rd_data;
  } reply_word_t;

  int fail_count = 0;

  // Print one line per mismatch and keep a running count.
  task automatic report(input string msg);
    $display("MISMATCH %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Modbus slave behavior: frame assembly, register windows and reply
  // packing. It also holds the queue of reply words still owed by the block.
  class mbrs_scoreboard;
    logic [7:0]  frame_q[$];
    logic [15:0] hold_mem[256];
    logic [15:0] inp_mem[256];
    logic [7:0]  my_addr;
    logic [15:0] hold_base, inp_base;
    logic [8:0]  hold_size, inp_size;
    reply_word_t owed_q[$];
    int          replies_seen;

    function new();
      foreach (hold_mem[i]) begin
        hold_mem[i] = '0;
        inp_mem[i] = '0;
      end
      my_addr = 8'd1;
      hold_base = '0; inp_base = '0; hold_size = '0; inp_size = '0;
      replies_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        CFG_SLAVE_ADDRESS: my_addr = val[7:0];
        CFG_HOLDING_BASE:  hold_base = val;
        CFG_HOLDING_SIZE:  hold_size = val[8:0];
        CFG_INPUT_BASE:    inp_base = val;
        CFG_INPUT_SIZE:    inp_size = val[8:0];
        default: ;
      endcase
    endfunction

    function automatic logic [15:0] crc_over(ref logic [7:0] b[$], input int n);
      logic [15:0] c;
      c = 16'hFFFF;
      for (int i = 0; i < n; i++) begin
        c ^= {8'h00, b[i]};
        for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
    endfunction

    // Sizes above 256 clamp to the store depth; ranges never wrap.
    function automatic bit fits(logic [15:0] base, logic [8:0] size, int start, int cnt);
      int lim;
      lim = (size > 256) ? 256 : size;
      if (start < base) return 0;
      if (start + cnt > 65536) return 0;
      return (start + cnt - base) <= lim;
    endfunction

    function automatic int w16(int i);
      return {frame_q[i], frame_q[i+1]};
    endfunction

    function automatic void exc(ref logic [7:0] r[$], input logic [7:0] fc, logic [7:0] code);
      r = {my_addr, fc | FC_EXC_FLAG, code};
    endfunction

    // Build the reply payload; return 0 when the frame is dropped.
    function automatic bit serve(ref logic [7:0] r[$]);
      int n, start, cnt, bc;
      logic [15:0] c;
      logic [7:0] fc;
      bit hold;
      n = frame_q.size();
      r = {};
      if (n < 4) return 0;
      if (frame_q[0] != my_addr) return 0;
      c = crc_over(frame_q, n - 2);
      if (frame_q[n-2] != c[7:0] || frame_q[n-1] != c[15:8]) return 0;
      fc = frame_q[1];
      if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT) begin
        hold = (fc == FC_READ_HOLDING);
        if (n != 8) begin exc(r, fc, EXC_ILLEGAL_VAL); return 1; end
        start = w16(2); cnt = w16(4);
        if (cnt == 0 || cnt > READ_MAX) begin exc(r, fc, EXC_ILLEGAL_VAL); return 1; end
        if (!fits(hold ? hold_base : inp_base, hold ? hold_size : inp_size, start, cnt))
        begin
          exc(r, fc, EXC_ILLEGAL_ADDR); return 1;
        end
        r = {my_addr, fc, 8'(cnt * 2)};
        for (int i = 0; i < cnt; i++) begin
          logic [15:0] v;
          v = hold ? hold_mem[start - hold_base + i] : inp_mem[start - inp_base + i];
          r.push_back(v[15:8]);
          r.push_back(v[7:0]);
        end
      end else if (fc == FC_WRITE_SINGLE) begin
        if (n != 8) begin exc(r, fc, EXC_ILLEGAL_VAL); return 1; end
        start = w16(2);
        if (!fits(hold_base, hold_size, start, 1)) begin
          exc(r, fc, EXC_ILLEGAL_ADDR); return 1;
        end
        hold_mem[start - hold_base] = 16'(w16(4));
        for (int i = 0; i < 6; i++) r.push_back(frame_q[i]);
      end else if (fc == FC_WRITE_MULTI) begin
        if (n < 9) begin exc(r, fc, EXC_ILLEGAL_VAL); return 1; end
        start = w16(2); cnt = w16(4); bc = frame_q[6];
        if (cnt == 0 || cnt > WRITE_MAX || bc != cnt * 2 || n != 9 + bc) begin
          exc(r, fc, EXC_ILLEGAL_VAL); return 1;
        end
        if (!fits(hold_base, hold_size, start, cnt)) begin
          exc(r, fc, EXC_ILLEGAL_ADDR); return 1;
        end
        for (int i = 0; i < cnt; i++) hold_mem[start - hold_base + i] = 16'(w16(7 + 2*i));
        r = {my_addr, fc};
        for (int i = 2; i < 6; i++) r.push_back(frame_q[i]);
      end else begin
        exc(r, fc, EXC_ILLEGAL_FC);
      end
      return 1;
    endfunction

    // Note one accepted input item and queue the reply words it causes.
    function void note_input(logic [1:0] kind, logic [7:0] rx, logic bank,
                             logic [15:0] addr, logic [15:0] val);
      logic [7:0] r[$];
      logic [15:0] c;
      reply_word_t w;
      case (kind)
        KIND_RX_BYTE: begin
          if (frame_q.size() >= 256) frame_q = {};
          frame_q.push_back(rx);
        end
        KIND_SILENCE: begin
          if (frame_q.size() != 0) begin
            if (serve(r)) begin
              c = crc_over(r, r.size());
              r.push_back(c[7:0]);
              r.push_back(c[15:8]);
              for (int k = 0; k < r.size(); k += 4) begin
                w = '0;
                for (int j = 0; j < 4 && k + j < r.size(); j++) begin
                  w.bytes[8*j +: 8] = r[k+j];
                  w.count++;
                end
                w.last = (k + 4 >= r.size());
                owed_q.push_back(w);
              end
            end
            frame_q = {};
          end
        end
        KIND_LWRITE: begin
          if (bank == 0) begin
            if (fits(hold_base, hold_size, addr, 1)) hold_mem[addr - hold_base] = val;
          end else if (fits(inp_base, inp_size, addr, 1)) inp_mem[addr - inp_base] = val;
        end
        default: begin
          w = '0;
          if (bank == 0) begin
            if (fits(hold_base, hold_size, addr, 1)) w.rd_data = hold_mem[addr - hold_base];
          end else if (fits(inp_base, inp_size, addr, 1)) w.rd_data = inp_mem[addr - inp_base];
          owed_q.push_back(w);
        end
      endcase
    endfunction

    // Compare one output transfer with the oldest owed word.
    task check_reply(reply_word_t got);
      reply_word_t exp_w;
      replies_seen++;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected transfer %h", got));
        return;
      end
      exp_w = owed_q.pop_front();
      if (got.bytes !== exp_w.bytes)
        report($sformatf("tx_bytes %h, want %h", got.bytes, exp_w.bytes));
      if (got.count !== exp_w.count)
        report($sformatf("tx_count %0d, want %0d", got.count, exp_w.count));
      if (got.last !== exp_w.last)
        report($sformatf("tlast %b, want %b", got.last, exp_w.last));
      if (got.rd_data !== exp_w.rd_data)
        report($sformatf("local_read_data %h, want %h", got.rd_data, exp_w.rd_data));
    endtask
  endclass

  logic                  clk, rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid, s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;   // rx_byte, local_bank, local_addr, local_value
  logic [1:0]            s_tuser;   // kind
  logic                  m_tvalid, m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;   // tx_bytes, tx_count, local_read_data
  logic                  m_tlast;

  modbus_rtu_register_server dut (.*);

  mbrs_scoreboard sb = new();
  bit idle_en = 1;        // cleared during the stretch with no idling
  int items_sent = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far above the slowest correct run.
  initial begin
    #50ms;
    $display("modbus_rtu_register_server verification failed");
    $finish;
  end

  // Sample output transfers at the rising edge; pick tready at the falling one.
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready)
      sb.check_reply({m_tdata[31:0], m_tdata[34:32], m_tlast, m_tdata[50:35]});

  always @(negedge clk)
    m_tready <= rst ? 1'b0 : !(idle_en && $urandom_range(99) < 29);

  // Send one item, idling first at random; hold it until the transfer.
  task automatic send_item(logic [1:0] kind, logic [7:0] rx = 0, logic bank = 0,
                           logic [15:0] addr = 0, logic [15:0] val = 0);
    while (idle_en && $urandom_range(99) < 29) @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = {7'd0, val, addr, bank, rx};
    do @(posedge clk); while (!s_tready);
    sb.note_input(kind, rx, bank, addr, val);
    items_sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic send_frame(logic [7:0] b[$], bit add_crc = 1);
    logic [15:0] c;
    if (add_crc) begin
      c = sb.crc_over(b, b.size());
      b.push_back(c[7:0]);
      b.push_back(c[15:8]);
    end
    foreach (b[i]) send_item(KIND_RX_BYTE, b[i]);
    send_item(KIND_SILENCE);
  endtask

  // Wait for every owed word, then let a possible dropped frame finish.
  task automatic drain();
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic setup(logic [7:0] a, logic [15:0] hb, logic [8:0] hs,
                       logic [15:0] ib, logic [8:0] is_);
    write_reg(CFG_SLAVE_ADDRESS, a);
    write_reg(CFG_HOLDING_BASE, hb);
    write_reg(CFG_HOLDING_SIZE, hs);
    write_reg(CFG_INPUT_BASE, ib);
    write_reg(CFG_INPUT_SIZE, is_);
  endtask

  // One request with random content, mostly near the windows; some are malformed, foreign or carry a broken CRC.
  task automatic random_request();
    logic [7:0] f[$];
    logic [15:0] st, cnt;
    int pick;
    pick = $urandom_range(9);
    st = ($urandom_range(3) == 0) ? 16'($urandom) :
         16'(sb.hold_base + $urandom_range(20) - 2);
    cnt = ($urandom_range(7) == 0) ? 16'($urandom_range(130)) : 16'($urandom_range(1, 6));
    case (pick)
      0, 1, 2: f = {sb.my_addr, FC_READ_HOLDING, st[15:8], st[7:0], cnt[15:8], cnt[7:0]};
      3, 4: begin
        st = 16'(sb.inp_base + $urandom_range(20) - 2);
        f = {sb.my_addr, FC_READ_INPUT, st[15:8], st[7:0], cnt[15:8], cnt[7:0]};
      end
      5, 6: f = {sb.my_addr, FC_WRITE_SINGLE, st[15:8], st[7:0],
                 8'($urandom), 8'($urandom)};
      7, 8: begin
        if (cnt > 8) cnt = 16'($urandom_range(1, 4));
        f = {sb.my_addr, FC_WRITE_MULTI, st[15:8], st[7:0], cnt[15:8], cnt[7:0],
             8'(cnt * 2)};
        for (int i = 0; i < 2 * cnt; i++) f.push_back(8'($urandom));
        if ($urandom_range(7) == 0) f.push_back(8'($urandom));
      end
      default: f = {sb.my_addr, 8'($urandom), 8'($urandom), 8'($urandom)};
    endcase
    if ($urandom_range(11) == 0) f[0] = f[0] ^ 8'h01;   // foreign address
    if ($urandom_range(11) == 0) begin
      foreach (f[i]) send_item(KIND_RX_BYTE, f[i]);      // broken CRC
      send_item(KIND_RX_BYTE, 8'($urandom));
      send_item(KIND_RX_BYTE, 8'($urandom));
      send_item(KIND_SILENCE);
    end else send_frame(f);
  endtask

  initial begin
    logic [7:0] f[$];
    rst = 1; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    s_tvalid = 0; s_tdata = '0; s_tuser = KIND_RX_BYTE;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed part: extremes, every function code and each error reply.
    setup(8'd1, 16'd0, 9'd256, 16'hFFF0, 9'd16);
    send_item(KIND_SILENCE);                                   // silence on empty buffer
    send_item(KIND_LWRITE, 0, 1'b1, 16'hFFFF, 16'hFFFF);
    send_item(KIND_LWRITE, 0, 1'b0, 16'd255, 16'hA5A5);
    send_item(KIND_LREAD, 0, 1'b1, 16'hFFFF);
    send_item(KIND_LREAD, 0, 1'b0, 16'd256);                  // outside window
    send_frame({8'd1, FC_WRITE_SINGLE, 8'h00, 8'h07, 8'h12, 8'h34});
    send_frame({8'd1, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'd125});
    send_frame({8'd1, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'd126});
    send_frame({8'd1, FC_READ_INPUT, 8'hFF, 8'hF0, 8'h00, 8'd17});
    send_frame({8'd1, FC_WRITE_MULTI, 8'h00, 8'h02, 8'h00, 8'h02, 8'd4,
                8'h11, 8'h22, 8'h33, 8'h44});
    send_frame({8'd1, FC_WRITE_MULTI, 8'h00, 8'h02, 8'h00, 8'h02, 8'd3, 8'h11});
    send_frame({8'd1, 8'h2B, 8'h00});                          // unknown code
    send_frame({8'd1, FC_READ_HOLDING}, 0);                    // short frame
    drain();

    setup(8'd255, 16'hFF00, 9'd0, 16'd0, 9'd300);
    send_frame({8'd255, FC_READ_HOLDING, 8'hFF, 8'h00, 8'h00, 8'h01});
    send_item(KIND_LWRITE, 0, 1'b1, 16'd200, 16'h5A5A);
    send_frame({8'd255, FC_READ_INPUT, 8'h00, 8'd199, 8'h00, 8'h02});
    drain();

    // Random part: mostly well-formed requests, some noise and local accesses.
    for (int ph = 0; ph < 2; ph++) begin
      setup(8'($urandom), 16'($urandom_range(0, 1) ? $urandom : 0),
            9'($urandom_range(0, 300)), 16'($urandom_range(0, 65535)),
            9'($urandom_range(0, 300)));
      idle_en = (ph != 1);
      for (int n = 0; n < 3; n++) begin
        case ($urandom_range(7))
          0: send_item(KIND_LWRITE, 8'($urandom), 1'($urandom),
                       16'(($urandom_range(1) ? sb.hold_base : sb.inp_base) +
                           $urandom_range(30)), 16'($urandom));
          1: send_item(KIND_LREAD, 8'($urandom), 1'($urandom),
                       16'(($urandom_range(1) ? sb.hold_base : sb.inp_base) +
                           $urandom_range(30)), 16'($urandom));
          2: begin
            repeat ($urandom_range(1, 6)) send_item(KIND_RX_BYTE, 8'($urandom));
            send_item(KIND_SILENCE);
          end
          default: random_request();
        endcase
      end
      drain();
    end
    idle_en = 1;

    $display("Sent %0d items over four register settings; checked %0d output transfers.",
             items_sent, sb.replies_seen);
    if (fail_count == 0 && sb.owed_q.size() == 0)
      $display("modbus_rtu_register_server verification clean");
    else begin
      if (sb.owed_q.size() != 0) report($sformatf("%0d transfers never came", sb.owed_q.size()));
      $display("modbus_rtu_register_server verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
